[design/ole_pkg.sv]
// shared types, command and status codes for the ordered list engine
// no dependencies; imported by ole_ctrl, ole_rsp_reg and ordered_list_engine

package ole_pkg;

   localparam int OLE_CAPACITY = 16;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 4;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 5;

   localparam logic [CMD_W-1:0] CMD_CREATE   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_MID  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_INS_TAIL = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_MID  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 4'd6;
   localparam logic [CMD_W-1:0] CMD_COUNT    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PRINT    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_REVERSE  = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } ole_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [LENGTH_W-1:0]      length;
      logic signed [DATA_W-1:0] element;
      logic                     element_valid;
      logic                     last;
   } ole_rsp_type;

endpackage

[design/ole_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies

module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ole_rsp_reg.sv]
// output register between the sequencer and the result channel
// depends on ole_pkg for the result item type

module ole_rsp_reg import ole_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  ole_rsp_type push_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ole_rsp_type rsp_item
);

   logic        valid_ff;
   logic        valid_in;
   ole_rsp_type item_ff;
   ole_rsp_type item_in;

   assign push_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
         item_in  = push_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[design/ole_ctrl.sv]
// command sequencer: decodes an item and walks the list store, shifting one entry a cycle
// depends on ole_pkg; drives the list ram and the output register

module ole_ctrl import ole_pkg::*; #(
   parameter int CAPACITY = OLE_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ole_req_type                 req_item,
   output logic                        push_valid,
   input  logic                        push_ready,
   output ole_rsp_type                 push_item,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output logic [DATA_W-1:0]           mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  logic [DATA_W-1:0]           mem_rd_data
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_LAST,
      ST_PUT,
      ST_RV_RA,
      ST_RV_RB,
      ST_RV_WA,
      ST_RV_WB,
      ST_PR_RD,
      ST_PR_OUT,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                ins_ff, ins_in;
   logic                wpend_ff, wpend_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       lim_ff, lim_in;
   logic [AW-1:0]       dst_ff, dst_in;
   logic [AW-1:0]       put_ff, put_in;
   logic [DATA_W-1:0]   tmp_ff, tmp_in;

   logic [CMP_W-1:0]    len_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic [AW-1:0]       pos_idx;
   logic [AW-1:0]       len_idx;
   logic [AW-1:0]       tail_idx;
   logic [AW-1:0]       ptr_inc;
   logic [AW-1:0]       ptr_dec;
   logic [AW-1:0]       lim_dec;
   logic [LEN_W+LENGTH_W-1:0] len_wide;
   logic                is_empty;
   logic                is_full;
   logic                mid_ins_ok;
   logic                mid_del_ok;
   logic                last_elem;
   logic                start_ins;
   logic                start_del;
   logic [AW-1:0]       k_idx;

   assign len_ext    = CMP_W'(len_ff);
   assign pos_ext    = CMP_W'(pos_ff);
   assign pos_idx    = AW'(pos_ext - CMP_W'(1));
   assign len_idx    = AW'(len_ff);
   assign tail_idx   = AW'(len_ff - LEN_W'(1));
   assign ptr_inc    = ptr_ff + AW'(1);
   assign ptr_dec    = ptr_ff - AW'(1);
   assign lim_dec    = lim_ff - AW'(1);
   assign len_wide   = (LEN_W + LENGTH_W)'(len_ff);
   assign is_empty   = (len_ff == '0);
   assign is_full    = (len_ff == LEN_W'(CAPACITY));
   assign mid_ins_ok = (pos_ext > CMP_W'(1)) && (pos_ext < len_ext);
   assign mid_del_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= len_ext);
   assign last_elem  = ((LEN_W'(ptr_ff) + LEN_W'(1)) == len_ff);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      status_in = status_ff;
      ins_in    = ins_ff;
      wpend_in  = wpend_ff;
      ptr_in    = ptr_ff;
      lim_in    = lim_ff;
      dst_in    = dst_ff;
      put_in    = put_ff;
      tmp_in    = tmp_ff;
      start_ins = 1'b0;
      start_del = 1'b0;
      k_idx     = '0;

      req_ready   = (state_ff == ST_IDLE);
      push_valid  = 1'b0;
      push_item.status        = status_ff;
      push_item.length        = len_wide[LENGTH_W-1:0];
      push_item.element       = '0;
      push_item.element_valid = 1'b0;
      push_item.last          = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = dst_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_item.cmd;
               value_in = req_item.value;
               pos_in   = req_item.position;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = STATUS_OK;
            state_in  = ST_DONE;
            wpend_in  = 1'b0;
            case (cmd_ff)
               CMD_CREATE: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = '0;
                  mem_wr_data = value_ff;
                  len_in      = LEN_W'(1);
               end
               CMD_INS_HEAD: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     start_ins = 1'b1;
                  end
               end
               CMD_INS_MID: begin
                  if (is_empty) begin
                     start_ins = 1'b1;
                  end else if (is_full) begin
                     status_in = STATUS_FULL;
                  end else if (mid_ins_ok) begin
                     start_ins = 1'b1;
                     k_idx     = pos_idx;
                  end else begin
                     status_in = STATUS_BADPOS;
                  end
               end
               CMD_INS_TAIL: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     start_ins = 1'b1;
                     k_idx     = len_idx;
                  end
               end
               CMD_DEL_HEAD: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     start_del = 1'b1;
                  end
               end
               CMD_DEL_MID: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else if (mid_del_ok) begin
                     start_del = 1'b1;
                     k_idx     = pos_idx;
                  end else begin
                     status_in = STATUS_BADPOS;
                  end
               end
               CMD_DEL_TAIL: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     len_in = len_ff - LEN_W'(1);
                  end
               end
               CMD_COUNT: begin
                  status_in = STATUS_OK;
               end
               CMD_PRINT: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ptr_in   = '0;
                     state_in = ST_PR_RD;
                  end
               end
               CMD_REVERSE: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else if (len_ff > LEN_W'(1)) begin
                     ptr_in   = '0;
                     lim_in   = tail_idx;
                     state_in = ST_RV_RA;
                  end
               end
               default: begin
                  status_in = STATUS_BADPOS;
               end
            endcase

            // insert: move entries k..len-1 up by one, top first
            if (start_ins) begin
               ins_in = 1'b1;
               put_in = k_idx;
               if (CMP_W'(k_idx) < len_ext) begin
                  ptr_in   = tail_idx;
                  lim_in   = k_idx;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_PUT;
               end
            end

            // delete: move entries k+1..len-1 down by one, bottom first
            if (start_del) begin
               ins_in = 1'b0;
               if ((CMP_W'(k_idx) + CMP_W'(1)) < len_ext) begin
                  ptr_in   = k_idx + AW'(1);
                  lim_in   = tail_idx;
                  state_in = ST_SHIFT;
               end else begin
                  len_in = len_ff - LEN_W'(1);
               end
            end
         end
         ST_SHIFT: begin
            // read one entry, write the one read in the previous cycle
            mem_rd_addr = ptr_ff;
            mem_wr_en   = wpend_ff;
            wpend_in    = 1'b1;
            dst_in      = ins_ff ? ptr_inc : ptr_dec;
            if (ptr_ff == lim_ff) begin
               state_in = ST_LAST;
            end else begin
               ptr_in = ins_ff ? ptr_dec : ptr_inc;
            end
         end
         ST_LAST: begin
            mem_wr_en = 1'b1;
            if (ins_ff) begin
               state_in = ST_PUT;
            end else begin
               len_in   = len_ff - LEN_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = put_ff;
            mem_wr_data = value_ff;
            len_in      = len_ff + LEN_W'(1);
            state_in    = ST_DONE;
         end
         ST_RV_RA: begin
            mem_rd_addr = ptr_ff;
            state_in    = ST_RV_RB;
         end
         ST_RV_RB: begin
            mem_rd_addr = lim_ff;
            tmp_in      = mem_rd_data;
            state_in    = ST_RV_WA;
         end
         ST_RV_WA: begin
            mem_rd_addr = lim_ff;
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            mem_wr_data = mem_rd_data;
            state_in    = ST_RV_WB;
         end
         ST_RV_WB: begin
            // finish the swap and fetch the next low entry
            mem_wr_en   = 1'b1;
            mem_wr_addr = lim_ff;
            mem_wr_data = tmp_ff;
            mem_rd_addr = ptr_inc;
            ptr_in      = ptr_inc;
            lim_in      = lim_dec;
            if (ptr_inc < lim_dec) begin
               state_in = ST_RV_RB;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PR_RD: begin
            mem_rd_addr = ptr_ff;
            state_in    = ST_PR_OUT;
         end
         ST_PR_OUT: begin
            push_valid              = 1'b1;
            push_item.status        = STATUS_OK;
            push_item.element       = mem_rd_data;
            push_item.element_valid = 1'b1;
            push_item.last          = last_elem;
            mem_rd_addr             = ptr_ff;
            if (push_ready) begin
               // fetch the next entry as this one leaves
               mem_rd_addr = ptr_inc;
               ptr_in      = ptr_inc;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         wpend_ff <= wpend_in;
      end
      cmd_ff    <= cmd_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      ins_ff    <= ins_in;
      ptr_ff    <= ptr_in;
      lim_ff    <= lim_in;
      dst_ff    <= dst_in;
      put_ff    <= put_in;
      tmp_ff    <= tmp_in;
   end

endmodule

[design/ordered_list_engine.sv]
// top level of the ordered list engine: sequencer, list ram and output register
// depends on ole_pkg, ole_ctrl, ole_ram and ole_rsp_reg

// Bounded ordered list of signed 32-bit values held in a single-port-write,
// single-port-read RAM of CAPACITY words; one item is worked on at a time and
// req_ready is high only while the sequencer is idle. Every item passes
// through decode, and the next item is taken in the idle cycle after its last
// result. Create, count, tail delete and refused commands then give their
// single result item. Inserting at one-based position p into a list of n
// entries moves entries p..n up, top first, then writes the value (only the
// write at the tail or into an empty list); deleting moves p+1..n down,
// bottom first, one entry moved per cycle because the RAM allows one read and
// one write each cycle. Print reads the first entry, then gives one item per
// cycle while the result side takes them. Reverse swaps end pairs inward.
// The list length resets to zero; the store needs no clearing pass, since only
// entries below the length are ever read. A result item waits in an output
// register, so the next item can be taken while it is still unclaimed.

module ordered_list_engine import ole_pkg::*; #(
   parameter int CAPACITY = OLE_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ole_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ole_rsp_type rsp_item
);

   localparam int AW = $clog2(CAPACITY);

   logic              push_valid;
   logic              push_ready;
   ole_rsp_type       push_item;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   ole_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ole_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ole_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
